FILE: design/lca_pkg.sv
// Shared types, sizes and helpers for the binary-lifting ancestor block.
// No dependencies; lca_core and tree_lca_binary_lifting import this package.
package lca_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int LEVELS     = 10;
  localparam int NODE_W     = 11;
  localparam int LVL_W      = 10;
  localparam int LEV_W      = $clog2(LEVELS);
  localparam int EDGE_SLOTS = 2 * (MAX_NODES - 1);
  localparam int SLOT_W     = 12;
  localparam int SP_W       = $clog2(MAX_NODES) + 1;
  localparam int JUMP_DEPTH = (MAX_NODES + 1) * LEVELS;
  localparam int JADDR_W    = $clog2(JUMP_DEPTH);
  localparam logic [SLOT_W-1:0] LIST_END = SLOT_W'(EDGE_SLOTS);

  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_E_WA, S_E_RB, S_E_WB,
    S_B_CLR, S_B_ROOT,
    S_W_TOP, S_W_TOPD, S_W_HEAD, S_W_SCAN, S_W_TGT, S_W_SEEN,
    S_F_RD1, S_F_RD2, S_F_WR,
    S_Q_LA, S_Q_LB, S_Q_UP, S_Q_UPD, S_Q_EQ,
    S_Q_LA2, S_Q_LB2, S_Q_CMP, S_Q_FIN, S_Q_ANS
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] count;
    logic              clr_ready;
  } cfg_t;

  function automatic logic [JADDR_W-1:0] jaddr(input logic [NODE_W-1:0] n,
                                               input logic [LEV_W-1:0] l);
    return JADDR_W'(n) * JADDR_W'(LEVELS) + JADDR_W'(l);
  endfunction

endpackage

FILE: design/lca_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lca_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lca_core.sv
// Sequencer for edge insertion, tree build and ancestor queries.
// Depends on lca_pkg and lca_ram; node, edge and jump-table storage lives in the RAM instances.
module lca_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lca_pkg::cfg_t              cfg,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [lca_pkg::NODE_W-1:0] in_node_a,
  input  logic [lca_pkg::NODE_W-1:0] in_node_b,
  output logic                       out_valid,
  output logic [lca_pkg::NODE_W-1:0] out_ancestor,
  output logic [1:0]                 out_status
);
  import lca_pkg::*;

  state_t state_r, state_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt, a_r, a_nxt, b_r, b_nxt, i_r, i_nxt;
  logic [NODE_W-1:0] top_r, top_nxt, v_r, v_nxt, p_r, p_nxt;
  logic [LVL_W-1:0]  la_r, la_nxt, lb_r, lb_nxt, diff_r, diff_nxt, toplvl_r, toplvl_nxt;
  logic [LEV_W-1:0]  lev_r, lev_nxt;
  logic [SLOT_W-1:0] fill_r, fill_nxt, e_r, e_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic              ready_r, ready_nxt, jz_r, jz_nxt;
  logic              ov_r, ov_nxt;
  logic [NODE_W-1:0] oa_r, oa_nxt;
  status_t           os_r, os_nxt;

  // RAM ports
  logic                  head_we, tgt_we, nxt_we, lvl_we, seen_we, jump_we, stk_we;
  logic [NODE_W-1:0]     head_wa, head_ra, lvl_wa, lvl_ra, seen_wa, seen_ra;
  logic [SLOT_W-1:0]     head_wd, head_rd, nxt_wd, nxt_rd;
  logic [NODE_W-1:0]     tgt_wa, tgt_ra, tgt_wd, tgt_rd, jump_wd, jump_rd, jump_q;
  logic [NODE_W-1:0]     stk_wd, stk_rd;
  logic [SP_W-2:0]       stk_wa, stk_ra;
  logic [LVL_W-1:0]      lvl_wd, lvl_rd;
  logic                  seen_wd, seen_rd;
  logic [JADDR_W-1:0]    jump_wa, jump_ra;

  lca_ram #(.DEPTH(MAX_NODES + 1), .DW(SLOT_W)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
  lca_ram #(.DEPTH(EDGE_SLOTS), .DW(NODE_W)) u_tgt (
    .clk, .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd));
  lca_ram #(.DEPTH(EDGE_SLOTS), .DW(SLOT_W)) u_nxt (
    .clk, .we(nxt_we), .waddr(tgt_wa), .wdata(nxt_wd), .raddr(tgt_ra), .rdata(nxt_rd));
  lca_ram #(.DEPTH(MAX_NODES + 1), .DW(LVL_W)) u_lvl (
    .clk, .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd));
  lca_ram #(.DEPTH(MAX_NODES + 1), .DW(1)) u_seen (
    .clk, .we(seen_we), .waddr(seen_wa), .wdata(seen_wd), .raddr(seen_ra), .rdata(seen_rd));
  lca_ram #(.DEPTH(JUMP_DEPTH), .DW(NODE_W)) u_jump (
    .clk, .we(jump_we), .waddr(jump_wa), .wdata(jump_wd), .raddr(jump_ra), .rdata(jump_rd));
  lca_ram #(.DEPTH(MAX_NODES), .DW(NODE_W)) u_stk (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

  // Row zero of the jump table is never written; it always reads as zero.
  assign jump_q = jz_r ? '0 : jump_rd;

  logic  in_range, edge_full, v_ok, f_end, i_end;
  mode_t mode;
  assign mode      = mode_t'(in_mode);
  assign in_range  = (in_node_a != '0) && (in_node_a <= cfg.count) &&
                     (in_node_b != '0) && (in_node_b <= cfg.count);
  assign edge_full = (13'(fill_r) + 13'd2) > 13'(EDGE_SLOTS);
  assign v_ok      = (tgt_rd != '0) && (tgt_rd <= cfg.count);
  assign i_end     = i_r > cfg.count;
  assign f_end     = lev_r == LEV_W'(LEVELS);

  assign busy         = state_r != S_IDLE;
  assign out_valid    = ov_r;
  assign out_ancestor = oa_r;
  assign out_status   = os_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (clr_r == NODE_W'(MAX_NODES)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (mode)
            MODE_EDGE:  if (in_range && !edge_full) state_nxt = S_E_WA;
            MODE_BUILD: state_nxt = S_B_CLR;
            MODE_QUERY: if (in_range && ready_r) state_nxt = S_Q_LA;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_E_WA:   state_nxt = S_E_RB;
      S_E_RB:   state_nxt = S_E_WB;
      S_E_WB:   state_nxt = S_IDLE;
      S_B_CLR:  if (i_end) state_nxt = S_B_ROOT;
      S_B_ROOT: state_nxt = S_W_TOP;
      S_W_TOP:  state_nxt = (sp_r == '0) ? S_F_RD1 : S_W_TOPD;
      S_W_TOPD: state_nxt = S_W_HEAD;
      S_W_HEAD: state_nxt = S_W_SCAN;
      S_W_SCAN: state_nxt = (e_r >= LIST_END) ? S_W_TOP : S_W_TGT;
      S_W_TGT:  state_nxt = v_ok ? S_W_SEEN : S_W_SCAN;
      S_W_SEEN: state_nxt = (!seen_rd && sp_r < SP_W'(MAX_NODES)) ? S_W_TOP : S_W_SCAN;
      S_F_RD1: begin
        if (f_end) state_nxt = S_IDLE;
        else if (!i_end) state_nxt = S_F_RD2;
      end
      S_F_RD2:  state_nxt = S_F_WR;
      S_F_WR:   state_nxt = S_F_RD1;
      S_Q_LA:   state_nxt = S_Q_LB;
      S_Q_LB:   state_nxt = S_Q_UP;
      S_Q_UP: begin
        if (diff_r[lev_r]) state_nxt = S_Q_UPD;
        else if (lev_r == '0) state_nxt = S_Q_EQ;
      end
      S_Q_UPD:  state_nxt = (lev_r == '0) ? S_Q_EQ : S_Q_UP;
      S_Q_EQ:   state_nxt = (a_r == b_r) ? S_IDLE : S_Q_LA2;
      S_Q_LA2:  state_nxt = S_Q_LB2;
      S_Q_LB2:  state_nxt = S_Q_CMP;
      S_Q_CMP:  state_nxt = (lev_r == '0) ? S_Q_FIN : S_Q_LA2;
      S_Q_FIN:  state_nxt = S_Q_ANS;
      S_Q_ANS:  state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_nxt = clr_r; a_nxt = a_r; b_nxt = b_r; i_nxt = i_r; top_nxt = top_r;
    v_nxt = v_r; p_nxt = p_r; la_nxt = la_r; lb_nxt = lb_r; diff_nxt = diff_r;
    toplvl_nxt = toplvl_r; lev_nxt = lev_r; fill_nxt = fill_r; e_nxt = e_r;
    sp_nxt = sp_r; ready_nxt = ready_r; jz_nxt = jz_r;
    ov_nxt = 1'b0; oa_nxt = '0; os_nxt = ST_OK;
    head_we = 1'b0; head_wa = '0; head_wd = LIST_END; head_ra = '0;
    tgt_we = 1'b0; nxt_we = 1'b0; tgt_wa = fill_r[NODE_W-1:0]; tgt_wd = '0;
    nxt_wd = head_rd; tgt_ra = e_r[NODE_W-1:0];
    lvl_we = 1'b0; lvl_wa = i_r; lvl_wd = '0; lvl_ra = '0;
    seen_we = 1'b0; seen_wa = i_r; seen_wd = 1'b0; seen_ra = tgt_rd;
    jump_we = 1'b0; jump_wa = jaddr(i_r, '0); jump_wd = '0; jump_ra = '0;
    stk_we = 1'b0; stk_wa = sp_r[SP_W-2:0]; stk_wd = v_r;
    stk_ra = sp_r[SP_W-2:0] - 1'b1;

    if (cfg.clr_ready) ready_nxt = 1'b0;

    case (state_r)
      S_INIT: begin
        head_we = 1'b1;
        head_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        a_nxt   = in_node_a;
        b_nxt   = in_node_b;
        head_ra = in_node_a;
        lvl_ra  = in_node_a;
        i_nxt   = NODE_W'(1);
        if (start) begin
          case (mode)
            MODE_EDGE: begin
              if (!in_range) begin
                ov_nxt = 1'b1; os_nxt = ST_RANGE;
              end else if (edge_full) begin
                ov_nxt = 1'b1; os_nxt = ST_FULL;
              end
            end
            MODE_QUERY: begin
              if (!in_range) begin
                ov_nxt = 1'b1; os_nxt = ST_RANGE;
              end else if (!ready_r) begin
                ov_nxt = 1'b1; os_nxt = ST_NOT_BUILT;
              end
            end
            MODE_BUILD: ;
            default:    ov_nxt = 1'b1;
          endcase
        end
      end
      S_E_WA: begin
        tgt_we = 1'b1; nxt_we = 1'b1; tgt_wd = b_r;
        head_we = 1'b1; head_wa = a_r; head_wd = fill_r;
      end
      S_E_RB: head_ra = b_r;
      S_E_WB: begin
        tgt_wa = fill_r[NODE_W-1:0] + 1'b1;
        tgt_we = 1'b1; nxt_we = 1'b1; tgt_wd = a_r;
        head_we = 1'b1; head_wa = b_r; head_wd = fill_r + 1'b1;
        fill_nxt = fill_r + SLOT_W'(2);
        ready_nxt = 1'b0;
        ov_nxt = 1'b1;
      end
      S_B_CLR: begin
        if (!i_end) begin
          seen_we = 1'b1; lvl_we = 1'b1; jump_we = 1'b1;
          i_nxt = i_r + 1'b1;
        end
      end
      S_B_ROOT: begin
        sp_nxt = '0;
        if (cfg.count != '0) begin
          seen_we = 1'b1; seen_wa = NODE_W'(1); seen_wd = 1'b1;
          stk_we = 1'b1; stk_wa = '0; stk_wd = NODE_W'(1);
          sp_nxt = SP_W'(1);
        end
      end
      S_W_TOP: begin
        i_nxt = NODE_W'(1);
        lev_nxt = LEV_W'(1);
      end
      S_W_TOPD: begin
        top_nxt = stk_rd;
        head_ra = stk_rd;
        lvl_ra  = stk_rd;
      end
      S_W_HEAD: begin
        e_nxt = head_rd;
        toplvl_nxt = lvl_rd;
      end
      S_W_SCAN: begin
        if (e_r >= LIST_END) sp_nxt = sp_r - 1'b1;
      end
      S_W_TGT: begin
        v_nxt = tgt_rd;
        e_nxt = nxt_rd;
      end
      S_W_SEEN: begin
        if (!seen_rd && sp_r < SP_W'(MAX_NODES)) begin
          seen_we = 1'b1; seen_wa = v_r; seen_wd = 1'b1;
          lvl_we = 1'b1; lvl_wa = v_r; lvl_wd = toplvl_r + 1'b1;
          jump_we = 1'b1; jump_wa = jaddr(v_r, '0); jump_wd = top_r;
          stk_we = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
      end
      S_F_RD1: begin
        if (f_end) begin
          ready_nxt = 1'b1;
          ov_nxt = 1'b1;
        end else if (i_end) begin
          i_nxt = NODE_W'(1);
          lev_nxt = lev_r + 1'b1;
        end else begin
          jump_ra = jaddr(i_r, lev_r - 1'b1);
          jz_nxt = 1'b0;
        end
      end
      S_F_RD2: begin
        jump_ra = jaddr(jump_q, lev_r - 1'b1);
        jz_nxt = jump_q == '0;
      end
      S_F_WR: begin
        jump_we = 1'b1; jump_wa = jaddr(i_r, lev_r); jump_wd = jump_q;
        i_nxt = i_r + 1'b1;
      end
      S_Q_LA: begin
        la_nxt = lvl_rd;
        lvl_ra = b_r;
      end
      S_Q_LB: begin
        // Put the deeper node in b.
        if (la_r > lvl_rd) begin
          a_nxt = b_r; b_nxt = a_r;
          la_nxt = lvl_rd; lb_nxt = la_r;
          diff_nxt = la_r - lvl_rd;
        end else begin
          lb_nxt = lvl_rd;
          diff_nxt = lvl_rd - la_r;
        end
        lev_nxt = LEV_W'(LEVELS - 1);
      end
      S_Q_UP: begin
        jump_ra = jaddr(b_r, lev_r);
        jz_nxt = b_r == '0;
        if (!diff_r[lev_r] && lev_r != '0) lev_nxt = lev_r - 1'b1;
      end
      S_Q_UPD: begin
        b_nxt = jump_q;
        diff_nxt[lev_r] = 1'b0;
        if (lev_r != '0) lev_nxt = lev_r - 1'b1;
      end
      S_Q_EQ: begin
        lev_nxt = LEV_W'(LEVELS - 1);
        if (a_r == b_r) begin
          ov_nxt = 1'b1; oa_nxt = a_r;
        end
      end
      S_Q_LA2: begin
        jump_ra = jaddr(a_r, lev_r);
        jz_nxt = a_r == '0;
      end
      S_Q_LB2: begin
        p_nxt = jump_q;
        jump_ra = jaddr(b_r, lev_r);
        jz_nxt = b_r == '0;
      end
      S_Q_CMP: begin
        if (p_r != jump_q) begin
          a_nxt = p_r; b_nxt = jump_q;
        end
        if (lev_r != '0) lev_nxt = lev_r - 1'b1;
      end
      S_Q_FIN: begin
        jump_ra = jaddr(a_r, '0);
        jz_nxt = a_r == '0;
      end
      S_Q_ANS: begin
        ov_nxt = 1'b1; oa_nxt = jump_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      fill_r  <= '0;
      sp_r    <= '0;
      ready_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fill_r  <= fill_nxt;
      sp_r    <= sp_nxt;
      ready_r <= ready_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; i_r <= i_nxt; top_r <= top_nxt; v_r <= v_nxt;
    p_r <= p_nxt; la_r <= la_nxt; lb_r <= lb_nxt; diff_r <= diff_nxt;
    toplvl_r <= toplvl_nxt; lev_r <= lev_nxt; e_r <= e_nxt; jz_r <= jz_nxt;
    oa_r <= oa_nxt; os_r <= os_nxt;
  end

endmodule

FILE: design/tree_lca_binary_lifting.sv
// Lowest common ancestor by binary lifting. A rejected or unused item is answered from the
// idle state, an edge writes its two list entries, and a query or a build steps through the
// memories, each of which has one read port. One transaction at a time; each result is
// strobed for one cycle and the receiver cannot hold it off. After reset a pass over every
// head entry empties the neighbour lists, busy high.
module tree_lca_binary_lifting (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [lca_pkg::NODE_W-1:0] in_node_a,
  input  logic [lca_pkg::NODE_W-1:0] in_node_b,
  output logic                       out_valid,
  output logic [lca_pkg::NODE_W-1:0] out_ancestor,
  output logic [1:0]                 out_status
);
  import lca_pkg::*;

  logic [NODE_W-1:0] node_count_r, node_count_nxt;
  logic [NODE_W-1:0] live_count;
  logic              wr_hit;
  cfg_t              cfg;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = {21'd0, node_count_r};
  assign node_count_nxt = wr_hit ? pwdata[NODE_W-1:0] : node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(MAX_NODES);
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  // Counts above the node store act as the store size.
  assign live_count = (node_count_r > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                           : node_count_r;
  assign cfg = {live_count, wr_hit};

  lca_core u_core (
    .clk, .rst_n, .cfg, .start, .busy, .in_mode, .in_node_a, .in_node_b,
    .out_valid, .out_ancestor, .out_status);

endmodule
